// File: rtl/aawc_pkg.sv
// ----------------------------------------------------------------------------
// aawc_pkg: shared types and constants of the audio window cache control
// Payload structs, command codes, policy codes, register indexes, score limits and a command builder.
// ----------------------------------------------------------------------------
package aawc_pkg;

	typedef struct packed {
		logic signed [47:0] req_start;
		logic signed [31:0] req_count;
	} aawc_in_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [30:0] out_offset;
		logic [46:0] stream_start;
		logic [30:0] length;
		logic [23:0] cache_offset;
		logic [23:0] cache_capacity;
		logic [1:0]  policy_now;
		logic        last;
	} aawc_out_t;

	typedef struct packed {
		logic can_push;
		logic fin_ok;
		logic hold_v;
	} aawc_oq_sts_t;

	localparam logic [2:0] ACT_ZERO_FILL    = 3'd0;
	localparam logic [2:0] ACT_FETCH_OUT    = 3'd1;
	localparam logic [2:0] ACT_OUT_TO_CACHE = 3'd2;
	localparam logic [2:0] ACT_FETCH_CACHE  = 3'd3;
	localparam logic [2:0] ACT_SHIFT        = 3'd4;
	localparam logic [2:0] ACT_CACHE_TO_OUT = 3'd5;
	localparam logic [2:0] ACT_RESIZE       = 3'd6;

	localparam logic [1:0] POL_NONE     = 2'd0;
	localparam logic [1:0] POL_AUTO_OFF = 2'd1;
	localparam logic [1:0] POL_AUTO_ON  = 2'd2;
	localparam logic [1:0] POL_ALWAYS   = 2'd3;

	localparam logic [2:0] CFG_SAMPLE_BYTES  = 3'd0;
	localparam logic [2:0] CFG_TOTAL_SAMPLES = 3'd1;
	localparam logic [2:0] CFG_START_POLICY  = 3'd2;
	localparam logic [2:0] CFG_START_CACHE   = 3'd3;

	localparam int SCORE_MIN   = -2000000;
	localparam int SCORE_MAX   = 90;
	localparam int SCORE_OFF   = 80;
	localparam int SCORE_RESET = 20;

	function automatic aawc_out_t mk_cmd(input logic [2:0] act, input logic [30:0] ooff,
		input logic [46:0] ss, input logic [30:0] len, input logic [23:0] coff,
		input logic [23:0] cap);
		aawc_out_t r;
		r.action         = act;
		r.out_offset     = ooff;
		r.stream_start   = ss;
		r.length         = len;
		r.cache_offset   = coff;
		r.cache_capacity = cap;
		r.policy_now     = POL_NONE;
		r.last           = 1'b0;
		return r;
	endfunction

endpackage

// File: rtl/adaptive_audio_window_cache_control.sv
// ----------------------------------------------------------------------------
// adaptive_audio_window_cache_control: sliding-window audio cache controller
// Turns sample read requests into zero-fill, fetch, shift, copy and resize
// commands, with score-driven cache switching and window growth.
// ----------------------------------------------------------------------------
//   Channel   Signals                        Transfer when
//   input     in_valid, in_stall, in_data    in_valid && !in_stall
//   output    out_valid, out_stall, out_data out_valid && !out_stall
//   config    cfg_we, cfg_index, cfg_data    cfg_we
//
// Each window growth of a request runs the shared one-bit-per-cycle divider.
// A configuration write reapplies the start rule through the same divider,
// and no request is taken until it is done.
// A stalled output holds the sequencer at its next command.
// Reset is asynchronous and active low.
// ----------------------------------------------------------------------------
module adaptive_audio_window_cache_control #(
	parameter int MAX_CACHE_BYTES     = 8388608,
	parameter int AUTO_CACHE_BYTES    = 4194304,
	parameter int DEFAULT_CACHE_BYTES = 262144
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  aawc_pkg::aawc_in_t   in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output aawc_pkg::aawc_out_t  out_data,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_index,
	input  logic [46:0]          cfg_data
);
	import aawc_pkg::*;

	localparam int MAXB1 = MAX_CACHE_BYTES > AUTO_CACHE_BYTES ? MAX_CACHE_BYTES
		: AUTO_CACHE_BYTES;
	localparam int MAXB  = MAXB1 > DEFAULT_CACHE_BYTES ? MAXB1 : DEFAULT_CACHE_BYTES;
	localparam int BW    = $clog2(MAXB + 1);
	localparam int CW    = BW;
	localparam int SW    = BW + 7;

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_CHK   = 5'd1;
	localparam logic [4:0] S_RANGE = 5'd2;
	localparam logic [4:0] S_NEG   = 5'd3;
	localparam logic [4:0] S_TAIL  = 5'd4;
	localparam logic [4:0] S_TAIL2 = 5'd5;
	localparam logic [4:0] S_SCORE = 5'd6;
	localparam logic [4:0] S_AUTO  = 5'd7;
	localparam logic [4:0] S_OFF   = 5'd8;
	localparam logic [4:0] S_EXP   = 5'd9;
	localparam logic [4:0] S_LOOP  = 5'd10;
	localparam logic [4:0] S_SPAN  = 5'd11;
	localparam logic [4:0] S_SZ    = 5'd12;
	localparam logic [4:0] S_DIR   = 5'd13;
	localparam logic [4:0] S_DIR2  = 5'd14;
	localparam logic [4:0] S_WIN   = 5'd15;
	localparam logic [4:0] S_APP   = 5'd16;
	localparam logic [4:0] S_SHF   = 5'd17;
	localparam logic [4:0] S_SHF2  = 5'd18;
	localparam logic [4:0] S_MORE  = 5'd19;
	localparam logic [4:0] S_COPY  = 5'd20;
	localparam logic [4:0] S_FIN   = 5'd21;
	localparam logic [4:0] S_GDIV  = 5'd22;
	localparam logic [4:0] S_GWAIT = 5'd23;
	localparam logic [4:0] S_GROW  = 5'd24;
	localparam logic [4:0] S_CFG   = 5'd25;
	localparam logic [4:0] S_CW1   = 5'd26;
	localparam logic [4:0] S_CW2   = 5'd27;

	logic [6:0]  sb_q;
	logic [46:0] tot_q;
	logic [1:0]  spol_q;
	logic [23:0] scb_q;

	logic signed [21:0] score_q;
	logic signed [47:0] exp_q;
	logic [1:0]         pol_q;
	logic signed [48:0] ws_q;
	logic [CW-1:0]      fill_q;
	logic [CW-1:0]      cap_q;
	logic [CW-1:0]      maxcap_q;
	logic [7:0]         tsr_q;

	logic [4:0]         state_q;
	logic [4:0]         ret_q;
	logic signed [48:0] st_q;
	logic signed [32:0] cnt_q;
	logic signed [48:0] end_q;
	logic signed [48:0] rem_q;
	logic signed [48:0] shift_q;
	logic [30:0]        base_q;
	logic               flag_q;
	logic               on_q;
	logic               off_q;
	logic [1:0]         fpol_q;
	logic [BW-1:0]      bytes_q;
	logic [BW-1:0]      span_q;

	logic               div_start;
	logic [BW-1:0]      div_dvd;
	logic               div_busy;
	logic [BW-1:0]      div_quo;

	logic               em;
	aawc_out_t          ed;
	logic               go;
	logic               fin;
	aawc_oq_sts_t       sts;

	logic [6:0]         sbe;
	logic signed [49:0] st_w, cnt_w, end_w, ws_w, cap_w, fill_w, n_w, exp_w, base_w, rem_w;
	logic signed [49:0] sh_w, half_w, span_w, shf_w;
	logic signed [22:0] cs;
	logic [37:0]        pa;
	logic [37:0]        pr;
	logic [SW-1:0]      ps;
	logic [SW-1:0]      psr;
	logic [31:0]        cfgb32;
	logic [7:0]         tsr_n;

	assign sbe    = (sb_q == 7'd0) ? 7'd1 : sb_q;
	assign st_w   = 50'(st_q);
	assign cnt_w  = 50'(cnt_q);
	assign end_w  = 50'(end_q);
	assign ws_w   = 50'(ws_q);
	assign exp_w  = 50'(exp_q);
	assign rem_w  = 50'(rem_q);
	assign shf_w  = 50'(shift_q);
	assign cap_w  = $signed({{(50 - CW){1'b0}}, cap_q});
	assign fill_w = $signed({{(50 - CW){1'b0}}, fill_q});
	assign n_w    = $signed({3'b000, tot_q});
	assign base_w = $signed({19'd0, base_q});
	assign tsr_n  = (tsr_q == 8'd255) ? tsr_q : tsr_q + 8'd1;

	assign sh_w   = end_w - (ws_w + cap_w);
	assign half_w = (st_w - ws_w) >>> 1;
	assign span_w = ws_w + fill_w - st_w;

	assign pa     = 38'(cnt_q[30:0]) * 38'(sbe);
	assign pr     = (pa + 38'd8191) & ~38'd8191;
	assign ps     = SW'(span_q) * SW'(sbe);
	assign psr    = (ps + SW'(8192)) & ~SW'(8191);

	assign cfgb32 = (scb_q == 24'd0) ? 32'(DEFAULT_CACHE_BYTES)
		: (({8'd0, scb_q} > 32'(MAX_CACHE_BYTES)) ? 32'(MAX_CACHE_BYTES) : {8'd0, scb_q});

	always_comb begin
		cs = 23'(score_q);
		if (st_w < exp_w) begin
			cs = cs - 23'sd5;
		end else if (st_w > exp_w) begin
			cs = cs - 23'sd1;
		end else begin
			cs = cs + 23'sd1;
		end
		if (cs < 23'(SCORE_MIN)) begin
			cs = 23'(SCORE_MIN);
		end else if (cs > 23'(SCORE_MAX)) begin
			cs = 23'(SCORE_MAX);
		end
	end

	always_comb begin
		em = 1'b0;
		ed = mk_cmd(ACT_ZERO_FILL, '0, '0, '0, '0, '0);
		unique case (state_q)
			S_RANGE: begin
				if (tot_q == 47'd0 || end_w <= 50'sd0 || st_w >= n_w) begin
					em = 1'b1;
					ed = mk_cmd(ACT_ZERO_FILL, '0, '0, cnt_q[30:0], '0, '0);
				end
			end
			S_NEG: begin
				if (st_w < 50'sd0) begin
					em = 1'b1;
					ed = mk_cmd(ACT_ZERO_FILL, '0, '0, 31'(-st_w), '0, '0);
				end
			end
			S_TAIL2: begin
				if (flag_q) begin
					em = 1'b1;
					ed = mk_cmd(ACT_ZERO_FILL, 31'(base_w + rem_w), '0, 31'(cnt_w - rem_w),
						'0, '0);
				end
			end
			S_OFF: begin
				if (off_q) begin
					em = 1'b1;
					ed = mk_cmd(ACT_RESIZE, '0, '0, '0, '0, '0);
				end
			end
			S_EXP: begin
				if (pol_q == POL_NONE || pol_q == POL_AUTO_OFF) begin
					em = 1'b1;
					ed = mk_cmd(ACT_FETCH_OUT, base_q, st_q[46:0], cnt_q[30:0], '0, '0);
				end
			end
			S_DIR: begin
				em = 1'b1;
				ed = mk_cmd(ACT_FETCH_OUT, base_q, st_q[46:0], cnt_q[30:0], '0, '0);
			end
			S_DIR2: begin
				em = 1'b1;
				ed = mk_cmd(ACT_OUT_TO_CACHE, 31'(base_w + cnt_w - fill_w), '0,
					31'(fill_w), '0, '0);
			end
			S_WIN: begin
				if (st_w < ws_w || st_w > ws_w + cap_w) begin
					em = 1'b1;
					ed = mk_cmd(ACT_FETCH_CACHE, '0, st_q[46:0], cnt_q[30:0], '0, '0);
				end
			end
			S_SHF2: begin
				if (shf_w < fill_w) begin
					em = 1'b1;
					ed = mk_cmd(ACT_SHIFT, '0, '0, shift_q[30:0], '0, '0);
				end
			end
			S_MORE: begin
				em = 1'b1;
				ed = mk_cmd(ACT_FETCH_CACHE, '0, 47'(ws_w + fill_w),
					31'(end_w - (ws_w + fill_w)), 24'(fill_q), '0);
			end
			S_COPY: begin
				em = 1'b1;
				ed = mk_cmd(ACT_CACHE_TO_OUT, base_q, '0, cnt_q[30:0], 24'(st_w - ws_w), '0);
			end
			S_GROW: begin
				if (div_quo > cap_q) begin
					em = 1'b1;
					ed = mk_cmd(ACT_RESIZE, '0, '0, '0, '0, 24'(div_quo));
				end
			end
			default: begin
				em = 1'b0;
			end
		endcase
	end

	assign go  = !em || sts.can_push;
	assign fin = (state_q == S_FIN) && sts.fin_ok;

	always_comb begin
		div_start = 1'b0;
		div_dvd   = bytes_q;
		unique case (state_q)
			S_CFG: begin
				div_start = 1'b1;
				div_dvd   = BW'(MAX_CACHE_BYTES);
			end
			S_CW1: begin
				div_start = !div_busy && (pol_q == POL_AUTO_ON || pol_q == POL_ALWAYS);
				div_dvd   = BW'(cfgb32);
			end
			S_GDIV: begin
				div_start = 1'b1;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sb_q     <= 7'd4;
			tot_q    <= '0;
			spol_q   <= POL_AUTO_OFF;
			scb_q    <= '0;
			score_q  <= 22'(SCORE_RESET);
			exp_q    <= '0;
			pol_q    <= POL_AUTO_OFF;
			ws_q     <= '0;
			fill_q   <= '0;
			cap_q    <= '0;
			maxcap_q <= CW'(MAX_CACHE_BYTES / 4);
			tsr_q    <= '0;
			state_q  <= S_IDLE;
			ret_q    <= S_IDLE;
		end else if (cfg_we && cfg_index <= CFG_START_CACHE) begin
			unique case (cfg_index)
				CFG_SAMPLE_BYTES:  sb_q   <= cfg_data[6:0];
				CFG_TOTAL_SAMPLES: tot_q  <= cfg_data;
				CFG_START_POLICY:  spol_q <= cfg_data[1:0];
				default:           scb_q  <= cfg_data[23:0];
			endcase
			state_q <= S_CFG;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					state_q <= (cnt_q <= 33'sd0) ? S_IDLE : S_RANGE;
				end
				S_RANGE: begin
					if (em) begin
						if (go) begin
							state_q <= S_FIN;
						end
					end else begin
						state_q <= S_NEG;
					end
				end
				S_NEG: begin
					if (go) begin
						state_q <= S_TAIL;
					end
				end
				S_TAIL: begin
					state_q <= S_TAIL2;
				end
				S_TAIL2: begin
					if (go) begin
						state_q <= S_SCORE;
					end
				end
				S_SCORE: begin
					score_q <= 22'(cs);
					state_q <= S_AUTO;
				end
				S_AUTO: begin
					if (on_q) begin
						pol_q   <= POL_AUTO_ON;
						ret_q   <= S_OFF;
						state_q <= S_GDIV;
					end else begin
						state_q <= S_OFF;
					end
				end
				S_OFF: begin
					if (go) begin
						if (off_q) begin
							cap_q  <= '0;
							ws_q   <= '0;
							fill_q <= '0;
							pol_q  <= POL_AUTO_OFF;
						end
						state_q <= S_EXP;
					end
				end
				S_EXP: begin
					if (go) begin
						exp_q   <= end_q[47:0];
						state_q <= em ? S_FIN : S_LOOP;
					end
				end
				S_LOOP: begin
					if (cnt_w > cap_w) begin
						tsr_q <= tsr_n;
						if (tsr_n > 8'd2 && cap_q < maxcap_q) begin
							state_q <= S_SPAN;
						end else begin
							state_q <= S_DIR;
						end
					end else begin
						state_q <= S_WIN;
					end
				end
				S_SPAN: begin
					state_q <= S_SZ;
				end
				S_SZ: begin
					tsr_q   <= '0;
					ret_q   <= S_LOOP;
					state_q <= S_GDIV;
				end
				S_DIR: begin
					if (go) begin
						fill_q  <= (cnt_w < cap_w) ? cnt_q[CW-1:0] : cap_q;
						state_q <= S_DIR2;
					end
				end
				S_DIR2: begin
					if (go) begin
						ws_q    <= 49'(end_w - fill_w);
						state_q <= S_FIN;
					end
				end
				S_WIN: begin
					if (go) begin
						if (em) begin
							fill_q  <= cnt_q[CW-1:0];
							ws_q    <= st_q;
							state_q <= S_COPY;
						end else begin
							state_q <= S_APP;
						end
					end
				end
				S_APP: begin
					if (end_w > ws_w + fill_w) begin
						state_q <= (end_w > ws_w + cap_w) ? S_SHF : S_MORE;
					end else begin
						state_q <= S_COPY;
					end
				end
				S_SHF: begin
					state_q <= S_SHF2;
				end
				S_SHF2: begin
					if (go) begin
						if (em) begin
							ws_q   <= 49'(ws_w + shf_w);
							fill_q <= CW'(fill_w - shf_w);
						end else begin
							ws_q   <= 49'(end_w - cap_w);
							fill_q <= '0;
						end
						state_q <= S_MORE;
					end
				end
				S_MORE: begin
					if (go) begin
						fill_q  <= CW'(end_w - ws_w);
						state_q <= S_COPY;
					end
				end
				S_COPY: begin
					if (go) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (sts.fin_ok) begin
						state_q <= S_IDLE;
					end
				end
				S_GDIV: begin
					state_q <= S_GWAIT;
				end
				S_GWAIT: begin
					if (!div_busy) begin
						state_q <= S_GROW;
					end
				end
				S_GROW: begin
					if (go) begin
						if (em) begin
							cap_q <= div_quo;
							if (cap_q != '0) begin
								if (fill_q > div_quo) begin
									fill_q <= div_quo;
								end
							end else begin
								ws_q   <= '0;
								fill_q <= '0;
							end
						end
						state_q <= ret_q;
					end
				end
				S_CFG: begin
					pol_q <= (tot_q == 47'd0 && (spol_q == POL_AUTO_ON || spol_q == POL_ALWAYS))
						? POL_NONE : spol_q;
					ws_q    <= '0;
					fill_q  <= '0;
					cap_q   <= '0;
					tsr_q   <= '0;
					state_q <= S_CW1;
				end
				S_CW1: begin
					if (!div_busy) begin
						maxcap_q <= div_quo;
						state_q  <= div_start ? S_CW2 : S_IDLE;
					end
				end
				S_CW2: begin
					if (!div_busy) begin
						cap_q   <= div_quo;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				st_q  <= 49'(in_data.req_start);
				cnt_q <= 33'(in_data.req_count);
				base_q <= '0;
			end
			S_CHK: begin
				end_q <= 49'(st_w + cnt_w);
			end
			S_RANGE: begin
				fpol_q <= pol_q;
			end
			S_NEG: begin
				if (em && go) begin
					base_q <= 31'(-st_w);
					cnt_q  <= 33'(cnt_w + st_w);
					st_q   <= '0;
				end
			end
			S_TAIL: begin
				flag_q <= end_w > n_w;
				rem_q  <= 49'(n_w - st_w);
			end
			S_TAIL2: begin
				if (flag_q && go) begin
					cnt_q <= 33'(rem_w);
					end_q <= 49'(n_w);
				end
			end
			S_SCORE: begin
				on_q  <= pol_q == POL_AUTO_OFF && cs <= 23'sd0;
				off_q <= pol_q == POL_AUTO_ON && cs > 23'(SCORE_OFF);
				if (pol_q == POL_AUTO_OFF && cs <= 23'sd0) begin
					fpol_q <= POL_AUTO_ON;
				end else if (pol_q == POL_AUTO_ON && cs > 23'(SCORE_OFF)) begin
					fpol_q <= POL_AUTO_OFF;
				end else begin
					fpol_q <= pol_q;
				end
			end
			S_AUTO: begin
				bytes_q <= (pr > 38'(AUTO_CACHE_BYTES)) ? BW'(AUTO_CACHE_BYTES) : BW'(pr);
			end
			S_SPAN: begin
				if (span_w < cnt_w) begin
					span_q <= (cnt_w > 50'(MAX_CACHE_BYTES)) ? BW'(MAX_CACHE_BYTES)
						: BW'(cnt_w);
				end else begin
					span_q <= (span_w > 50'(MAX_CACHE_BYTES)) ? BW'(MAX_CACHE_BYTES)
						: BW'(span_w);
				end
			end
			S_SZ: begin
				bytes_q <= (psr > SW'(MAX_CACHE_BYTES)) ? BW'(MAX_CACHE_BYTES) : BW'(psr);
			end
			S_SHF: begin
				shift_q <= (half_w > sh_w) ? 49'(half_w) : 49'(sh_w);
			end
			default: begin
				flag_q <= flag_q;
			end
		endcase
	end

	assign in_stall = state_q != S_IDLE;

	aawc_div #(
		.NW(BW)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(div_dvd),
		.divisor(sbe),
		.busy(div_busy),
		.quotient(div_quo)
	);

	aawc_oq u_oq (
		.clk(clk),
		.arst_n(arst_n),
		.push(em && go && !(cfg_we && cfg_index <= CFG_START_CACHE)),
		.push_d(ed),
		.fin(fin && !(cfg_we && cfg_index <= CFG_START_CACHE)),
		.fpol(fpol_q),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.out_data(out_data),
		.sts(sts)
	);

	a_fill_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (fill_q <= cap_q))
		else $error("window fill exceeds capacity while idle");

	a_no_cache_when_off: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && (pol_q == POL_NONE || pol_q == POL_AUTO_OFF)) |-> (cap_q == '0))
		else $error("window capacity left over with the cache off");

	a_last_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.last) |-> sts.hold_v)
		else $error("non-final command shown with no command behind it");

endmodule

// File: rtl/aawc_div.sv
// ----------------------------------------------------------------------------
// aawc_div: iterative byte-to-sample divider
// Restoring division of a byte count by the sample size, one bit per cycle.
// ----------------------------------------------------------------------------
module aawc_div #(
	parameter int NW = 24
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] dividend,
	input  logic [6:0]    divisor,
	output logic          busy,
	output logic [NW-1:0] quotient
);
	localparam int KW = $clog2(NW + 1);

	logic [6:0]    rem_q;
	logic [NW-1:0] quo_q;
	logic [KW-1:0] cnt_q;
	logic          busy_q;
	logic [7:0]    trial;

	assign trial    = {rem_q, quo_q[NW-1]};
	assign busy     = busy_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= KW'(NW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == KW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			if (trial >= {1'b0, divisor}) begin
				rem_q <= 7'(trial - {1'b0, divisor});
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= trial[6:0];
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end
	end

endmodule

// File: rtl/aawc_oq.sv
// ----------------------------------------------------------------------------
// aawc_oq: command output stage
// Holds the newest command back until the next one or the end of the request
// is known, so that the final command carries the last mark.
// ----------------------------------------------------------------------------
module aawc_oq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  aawc_pkg::aawc_out_t   push_d,
	input  logic                  fin,
	input  logic [1:0]            fpol,
	input  logic                  out_stall,
	output logic                  out_valid,
	output aawc_pkg::aawc_out_t   out_data,
	output aawc_pkg::aawc_oq_sts_t sts
);
	import aawc_pkg::*;

	aawc_out_t hold_q;
	aawc_out_t out_q;
	logic      hv_q;
	logic      ov_q;
	logic      free;

	assign free         = !ov_q || !out_stall;
	assign sts.can_push = !hv_q || free;
	assign sts.fin_ok   = hv_q && free;
	assign sts.hold_v   = hv_q;
	assign out_valid    = ov_q;
	assign out_data     = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hv_q <= 1'b0;
			ov_q <= 1'b0;
		end else if (push) begin
			hv_q <= 1'b1;
			if (hv_q) begin
				ov_q <= 1'b1;
			end else if (ov_q && !out_stall) begin
				ov_q <= 1'b0;
			end
		end else if (fin) begin
			hv_q <= 1'b0;
			ov_q <= 1'b1;
		end else if (ov_q && !out_stall) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			hold_q <= push_d;
			if (hv_q) begin
				out_q            <= hold_q;
				out_q.policy_now <= fpol;
				out_q.last       <= 1'b0;
			end
		end else if (fin) begin
			out_q            <= hold_q;
			out_q.policy_now <= fpol;
			out_q.last       <= 1'b1;
		end
	end

endmodule
